// ===== hw/rtl/tcp_port_table_macros.svh =====
`ifndef TCP_PORT_TABLE_MACROS_SVH
`define TCP_PORT_TABLE_MACROS_SVH

// checked while out of reset
`define TPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tpt_pkg.sv =====
package tpt_pkg;

    localparam int PORTS_PER_RANGE = 32768;
    localparam int IDX_W           = $clog2(PORTS_PER_RANGE);
    localparam int WORD_W          = 32;
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int ROW_W           = IDX_W - BIT_W;
    localparam int ROWS            = PORTS_PER_RANGE / WORD_W;
    localparam int PORT_W          = 16;
    localparam int CNT_W           = IDX_W + 1;

    typedef enum logic [1:0] {
        CMD_QUERY    = 2'd0,
        CMD_OPEN     = 2'd1,
        CMD_GET_FREE = 2'd2,
        CMD_CLOSE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_FREE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic clear_last;
        t_cmd cmd;
        logic out_free;
        logic full;
        logic found;
    } t_sts;

endpackage

// ===== hw/rtl/tpt_ctrl.sv =====
module tpt_ctrl
    import tpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_command,
    input  t_sts       i_sts,
    output logic       o_cmd_ready,
    output t_ctl       o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_cmd_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = (t_cmd'(i_command) == CMD_GET_FREE) ? S_SEARCH : S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.cmd == CMD_CLOSE || i_sts.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (i_sts.full || i_sts.found) begin
                    if (i_sts.out_free) begin
                        o_ctl.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tpt_dp.sv =====
`include "tcp_port_table_macros.svh"

module tpt_dp
    import tpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [1:0]        i_command,
    input  logic [PORT_W-1:0] i_port,
    input  logic              i_rsp_ready,
    output t_sts              o_sts,
    output logic              o_rsp_valid,
    output logic [1:0]        o_reply_kind,
    output logic              o_ok,
    output logic [PORT_W-1:0] o_granted_port
);

    logic [WORD_W-1:0] listen_mem [ROWS];
    logic [WORD_W-1:0] active_mem [ROWS];

    logic [WORD_W-1:0] r_rdl;
    logic [WORD_W-1:0] r_rda;
    t_cmd              r_cmd;
    logic [PORT_W-1:0] r_key;
    logic [ROW_W-1:0]  r_row;
    logic              r_first;
    logic [IDX_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [ROW_W-1:0]  r_clr_row;
    logic              r_ovalid;
    t_kind             r_kind;
    logic              r_ok;
    logic [PORT_W-1:0] r_gport;

    logic [PORT_W-1:0] sw_port;
    logic [ROW_W-1:0]  ld_row;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_en;
    logic [BIT_W-1:0]  key_bit;
    logic [WORD_W-1:0] key_hot;
    logic              bit_l;
    logic              bit_a;
    logic [WORD_W-1:0] srch_mask;
    logic [WORD_W-1:0] free_bits;
    logic              found;
    logic              full;
    logic [BIT_W-1:0]  g_bit;
    logic [WORD_W-1:0] g_hot;
    logic [IDX_W-1:0]  g_idx;
    logic              open_ok;
    logic              close_hit;
    logic              grant;
    logic              l_we;
    logic [ROW_W-1:0]  l_wrow;
    logic [WORD_W-1:0] l_wdata;
    logic              a_we;
    logic [ROW_W-1:0]  a_wrow;
    logic [WORD_W-1:0] a_wdata;
    logic              out_free;

    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // read side
    assign sw_port = {i_port[7:0], i_port[15:8]};

    always_comb begin
        case (t_cmd'(i_command))
            CMD_QUERY:    ld_row = sw_port[IDX_W-1:BIT_W];
            CMD_GET_FREE: ld_row = r_ptr[IDX_W-1:BIT_W];
            default:      ld_row = i_port[IDX_W-1:BIT_W];
        endcase
    end

    assign rd_en  = i_ctl.load || i_ctl.step;
    assign rd_row = i_ctl.load ? ld_row : r_row + ROW_W'(1);

    // evaluation of the fetched words
    assign key_bit   = r_key[BIT_W-1:0];
    assign key_hot   = WORD_W'(1) << key_bit;
    assign bit_l     = r_rdl[key_bit];
    assign bit_a     = r_rda[key_bit];
    assign srch_mask = r_first ? ({WORD_W{1'b1}} << r_ptr[BIT_W-1:0]) : {WORD_W{1'b1}};
    assign free_bits = ~r_rda & srch_mask;
    assign found     = |free_bits;
    assign full      = (r_count == CNT_W'(PORTS_PER_RANGE));
    assign g_bit     = first_set(free_bits);
    assign g_hot     = WORD_W'(1) << g_bit;
    assign g_idx     = {r_row, g_bit};
    assign open_ok   = !r_key[PORT_W-1] && !bit_l;
    assign close_hit = r_key[PORT_W-1] && bit_a;
    assign grant     = i_ctl.finish && (r_cmd == CMD_GET_FREE) && !full;
    assign out_free  = !r_ovalid || i_rsp_ready;

    // write side
    always_comb begin
        l_we    = 1'b0;
        l_wrow  = r_row;
        l_wdata = r_rdl | key_hot;
        a_we    = 1'b0;
        a_wrow  = r_row;
        a_wdata = r_rda & ~key_hot;
        if (i_ctl.clear) begin
            l_we    = 1'b1;
            l_wrow  = r_clr_row;
            l_wdata = '0;
            a_we    = 1'b1;
            a_wrow  = r_clr_row;
            a_wdata = '0;
        end else if (i_ctl.finish) begin
            case (r_cmd)
                CMD_OPEN: begin
                    l_we = open_ok;
                end
                CMD_CLOSE: begin
                    a_we = close_hit;
                end
                CMD_GET_FREE: begin
                    a_we    = !full;
                    a_wdata = r_rda | g_hot;
                end
                default: begin
                    l_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            listen_mem[l_wrow] <= l_wdata;
        end
        if (rd_en) begin
            r_rdl <= listen_mem[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            active_mem[a_wrow] <= a_wdata;
        end
        if (rd_en) begin
            r_rda <= active_mem[rd_row];
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_key   <= (t_cmd'(i_command) == CMD_QUERY) ? sw_port : i_port;
            r_row   <= ld_row;
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_row   <= rd_row;
            r_first <= 1'b0;
        end
    end

    // allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_count   <= '0;
            r_clr_row <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            if (grant) begin
                r_ptr   <= g_idx + IDX_W'(1);
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctl.finish && r_cmd == CMD_CLOSE && close_hit) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.finish && r_cmd != CMD_CLOSE) begin
            r_ovalid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish && r_cmd != CMD_CLOSE) begin
            r_gport <= '0;
            case (r_cmd)
                CMD_QUERY: begin
                    r_kind <= KIND_QUERY;
                    r_ok   <= r_key[PORT_W-1] ? bit_a : bit_l;
                end
                CMD_OPEN: begin
                    r_kind <= KIND_OPEN;
                    r_ok   <= open_ok;
                end
                default: begin
                    r_kind <= KIND_FREE;
                    r_ok   <= !full;
                    if (!full) begin
                        r_gport <= {1'b1, g_idx};
                    end
                end
            endcase
        end
    end

    assign o_sts.clear_last = (r_clr_row == {ROW_W{1'b1}});
    assign o_sts.cmd        = r_cmd;
    assign o_sts.out_free   = out_free;
    assign o_sts.full       = full;
    assign o_sts.found      = found;

    assign o_rsp_valid    = r_ovalid;
    assign o_reply_kind   = r_kind;
    assign o_ok           = r_ok;
    assign o_granted_port = r_gport;

    `TPT_ASSERT(a_count_bound, r_count <= CNT_W'(PORTS_PER_RANGE), "port count overflow")
    `TPT_ASSERT(a_grant_clear, grant |-> found, "grant without a clear entry")
    `TPT_ASSERT(a_close_quiet, (i_ctl.finish && r_cmd == CMD_CLOSE) |=> !$rose(r_ovalid), "close produced a word")
    `TPT_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !r_ovalid, "response valid after reset")

endmodule

// ===== hw/rtl/tcp_port_table.sv =====
// tcp port table: listening map for ports 0x0000..0x7fff, active map for
// ephemeral ports 0x8000..0xffff, each held as 1024 rows of 32 bits
// command channel: i_cmd_valid / o_cmd_ready with i_command and i_port
// response channel: o_rsp_valid / i_rsp_ready with kind, ok and granted port
// query takes the port in bus byte order, open and close in host order
// close gives no response word; every other command gives exactly one
// query, open and close do one map row read, then one evaluate/write step
// get-free reads one active row per cycle, starting at the search pointer row,
// until a row with a clear bit is found; a full map answers failure after
// reading the pointer row, without searching
// reset: a clearing pass writes zero to all 1024 rows of both maps, one row
// a cycle, and o_cmd_ready stays low until the pass is done
// the response sits in an output register; a new command is taken while it
// waits, and a command that needs the register holds until it is taken
module tcp_port_table
    import tpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  logic [1:0]        i_command,
    input  logic [PORT_W-1:0] i_port,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [1:0]        o_reply_kind,
    output logic              o_ok,
    output logic [PORT_W-1:0] o_granted_port
);

    t_ctl ctl;
    t_sts sts;

    tpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_command   (i_command),
        .i_sts       (sts),
        .o_cmd_ready (o_cmd_ready),
        .o_ctl       (ctl)
    );

    tpt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_command      (i_command),
        .i_port         (i_port),
        .i_rsp_ready    (i_rsp_ready),
        .o_sts          (sts),
        .o_rsp_valid    (o_rsp_valid),
        .o_reply_kind   (o_reply_kind),
        .o_ok           (o_ok),
        .o_granted_port (o_granted_port)
    );

endmodule

// ===== bench/tcp_port_table_tb.sv =====
`timescale 1ns / 1ps

module tcp_port_table_tb;
    import tpt_pkg::*;

    localparam int EPH_BASE    = 32768;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 1100;

    typedef struct packed {
        t_kind             kind;
        logic              ok;
        logic [PORT_W-1:0] granted;
    } t_port_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cmd_valid = 1'b0;
    logic              o_cmd_ready;
    logic [1:0]        i_command = CMD_QUERY;
    logic [PORT_W-1:0] i_port = '0;
    logic              o_rsp_valid;
    logic              i_rsp_ready = 1'b0;
    logic [1:0]        o_reply_kind;
    logic              o_ok;
    logic [PORT_W-1:0] o_granted_port;

    // predicted table contents
    bit                listen_bits [PORTS_PER_RANGE];
    bit                active_bits [PORTS_PER_RANGE];
    logic [IDX_W-1:0]  next_fit_ptr = '0;

    t_port_reply       due_replies[$];
    logic [PORT_W-1:0] granted_ports[$];

    int errors          = 0;
    int words_sent      = 0;
    int replies_checked = 0;
    int ports_granted   = 0;
    int full_hits       = 0;
    int burst_left      = 0;
    int gap_pct         = 0;
    int stall_pct       = 0;
    int hold_asks       = 0;
    int hold_done       = 0;
    int hold_left       = 0;
    int stall_left      = 0;

    tcp_port_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_cmd_valid),
        .o_cmd_ready    (o_cmd_ready),
        .i_command      (i_command),
        .i_port         (i_port),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_reply_kind   (o_reply_kind),
        .o_ok           (o_ok),
        .o_granted_port (o_granted_port)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [PORT_W-1:0] swap_bytes(input logic [PORT_W-1:0] p);
        return {p[7:0], p[15:8]};
    endfunction

    function automatic void predict_table(input t_cmd cmd, input logic [PORT_W-1:0] port,
                                          output bit has_rep, output t_port_reply rep);
        logic [PORT_W-1:0] host;
        logic [IDX_W-1:0]  idx;
        int                n;
        has_rep     = 1'b1;
        rep.kind    = KIND_QUERY;
        rep.ok      = 1'b0;
        rep.granted = '0;
        case (cmd)
            CMD_QUERY: begin
                host   = swap_bytes(port);
                rep.ok = host[15] ? active_bits[host[14:0]] : listen_bits[host[14:0]];
            end
            CMD_OPEN: begin
                rep.kind = KIND_OPEN;
                if (!port[15] && !listen_bits[port[14:0]]) begin
                    listen_bits[port[14:0]] = 1'b1;
                    rep.ok = 1'b1;
                end
            end
            CMD_GET_FREE: begin
                rep.kind = KIND_FREE;
                // next-fit walk from the pointer
                for (n = 0; n < PORTS_PER_RANGE && !rep.ok; n++) begin
                    idx = next_fit_ptr + IDX_W'(n);
                    if (!active_bits[idx]) begin
                        active_bits[idx] = 1'b1;
                        next_fit_ptr     = idx + 1'b1;
                        rep.ok           = 1'b1;
                        rep.granted      = PORT_W'(EPH_BASE) | PORT_W'(idx);
                    end
                end
                if (rep.ok)
                    ports_granted++;
                else
                    full_hits++;
            end
            default: begin
                has_rep = 1'b0;
                if (port[15])
                    active_bits[port[14:0]] = 1'b0;
            end
        endcase
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [PORT_W-1:0] port,
                             output t_port_reply rep, output bit has_rep);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(99) < gap_pct) begin
                gap = $urandom_range(1, 12);
                i_cmd_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_cmd_valid <= 1'b1;
        i_command   <= cmd;
        i_port      <= port;
        do @(posedge i_clk); while (!o_cmd_ready);
        predict_table(cmd, port, has_rep, rep);
        if (has_rep)
            due_replies.push_back(rep);
        words_sent++;
    endtask

    // response side: long hold on request, otherwise short random stall runs
    always @(posedge i_clk) begin
        if (hold_done != hold_asks) begin
            hold_done   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_rsp_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_rsp_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_rsp_ready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left  <= $urandom_range(0, 5);
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_port_reply want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            replies_checked++;
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with none due, got kind %0d ok %0d port %h",
                         $time, o_reply_kind, o_ok, o_granted_port);
            end else begin
                want = due_replies.pop_front();
                if (o_reply_kind !== want.kind || o_ok !== want.ok ||
                    o_granted_port !== want.granted) begin
                    errors++;
                    $display("%0t: expected kind %0d ok %0d port %h, got kind %0d ok %0d port %h",
                             $time, want.kind, want.ok, want.granted,
                             o_reply_kind, o_ok, o_granted_port);
                end
            end
        end
    end

    task automatic set_idling(input int gaps, input int stalls);
        gap_pct = gaps;
        stall_pct <= stalls;
    endtask

    task automatic test_directed();
        t_port_reply rep;
        bit          got;
        set_idling(30, 20);
        send_word(CMD_QUERY, 16'h0000, rep, got);
        send_word(CMD_QUERY, 16'hFFFF, rep, got);
        send_word(CMD_QUERY, 16'h0080, rep, got);
        send_word(CMD_OPEN, 16'h0000, rep, got);
        send_word(CMD_OPEN, 16'h7FFF, rep, got);
        send_word(CMD_OPEN, 16'h0000, rep, got);
        send_word(CMD_OPEN, 16'h8000, rep, got);
        send_word(CMD_OPEN, 16'hFFFF, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h0000), rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h7FFF), rep, got);
        send_word(CMD_GET_FREE, 16'h0000, rep, got);
        send_word(CMD_GET_FREE, 16'hFFFF, rep, got);
        send_word(CMD_GET_FREE, 16'h5A5A, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h8001), rep, got);
        send_word(CMD_CLOSE, 16'h8001, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h8001), rep, got);
        send_word(CMD_CLOSE, 16'h0000, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h0000), rep, got);
        send_word(CMD_CLOSE, 16'hFFFF, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'hFFFF), rep, got);
        send_word(CMD_GET_FREE, 16'h1234, rep, got);
        send_word(CMD_QUERY, swap_bytes(16'h8003), rep, got);
    endtask

    task automatic run_mixed(input int count);
        int                start;
        int                pick;
        int                slot;
        logic [PORT_W-1:0] p;
        t_port_reply       rep;
        bit                got;
        start = words_sent;
        while (words_sent - start < count) begin
            if ($urandom_range(99) < 3)
                set_idling($urandom_range(2) * 25, $urandom_range(2) * 20);
            pick = $urandom_range(99);
            if (pick < 25) begin
                p = PORT_W'($urandom_range(EPH_BASE - 1));
                send_word(CMD_OPEN, p, rep, got);
                send_word(CMD_QUERY, swap_bytes(p), rep, got);
            end else if (pick < 50) begin
                send_word(CMD_GET_FREE, PORT_W'($urandom), rep, got);
                if (rep.ok) begin
                    p = rep.granted;
                    send_word(CMD_QUERY, swap_bytes(p), rep, got);
                    if ($urandom_range(1)) begin
                        send_word(CMD_CLOSE, p, rep, got);
                        send_word(CMD_QUERY, swap_bytes(p), rep, got);
                    end else begin
                        granted_ports.push_back(p);
                    end
                end
            end else if (pick < 65) begin
                if (granted_ports.size() != 0 && $urandom_range(1)) begin
                    slot = $urandom_range(granted_ports.size() - 1);
                    p    = granted_ports[slot];
                    granted_ports.delete(slot);
                end else begin
                    p = PORT_W'(EPH_BASE) | PORT_W'($urandom_range(EPH_BASE - 1));
                end
                send_word(CMD_CLOSE, p, rep, got);
                send_word(CMD_QUERY, swap_bytes(p), rep, got);
            end else if (pick < 75) begin
                send_word(CMD_QUERY, PORT_W'($urandom), rep, got);
            end else begin
                send_word(t_cmd'($urandom_range(3)), PORT_W'($urandom), rep, got);
            end
        end
    endtask

    task automatic test_backpressure();
        t_port_reply rep;
        bit          got;
        int          n;
        set_idling(0, 0);
        hold_asks <= hold_asks + 1;
        for (n = 0; n < 40; n++) begin
            if (n % 2)
                send_word(CMD_OPEN, PORT_W'($urandom), rep, got);
            else
                send_word(CMD_QUERY, PORT_W'($urandom), rep, got);
        end
    endtask

    task automatic test_grant_run();
        t_port_reply       rep;
        bit                got;
        logic [PORT_W-1:0] p;
        int                n;
        set_idling(5, 5);
        // long run of grants across several map rows
        for (n = 0; n < 100; n++)
            send_word(CMD_GET_FREE, PORT_W'($urandom), rep, got);
        // punch scattered holes and one run
        for (n = 0; n < 40; n++) begin
            p = PORT_W'(EPH_BASE) | PORT_W'($urandom_range(EPH_BASE - 1));
            send_word(CMD_CLOSE, p, rep, got);
        end
        p = PORT_W'(EPH_BASE) | PORT_W'($urandom_range(EPH_BASE - 1));
        for (n = 0; n < 30; n++)
            send_word(CMD_CLOSE, PORT_W'(EPH_BASE) | (p + PORT_W'(n)), rep, got);
        send_word(CMD_GET_FREE, PORT_W'($urandom), rep, got);
        send_word(CMD_GET_FREE, PORT_W'($urandom), rep, got);
    endtask

    task automatic drain_replies();
        i_cmd_valid <= 1'b0;
        set_idling(0, 10);
        while (due_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        run_mixed(650);
        test_backpressure();
        test_grant_run();
        run_mixed(550);
        drain_replies();
        $display("%0d command words sent, %0d replies checked", words_sent, replies_checked);
        $display("%0d ports granted, full map refused %0d times", ports_granted, full_hits);
        if (errors == 0 && due_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_ctrl.sv
hw/rtl/tpt_dp.sv
hw/rtl/tcp_port_table.sv
bench/tcp_port_table_tb.sv
